// ----- hw/rtl/rgbnv_pkg.sv -----
package rgbnv_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int POS_W = $clog2(MAX_DIMENSION);
  localparam int DIM_W = 13;
  localparam int CMP_W = (DIM_W > POS_W + 1) ? DIM_W : POS_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET = DIM_W'(1920);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(1080);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       chroma_valid;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic chroma_valid;
    logic frame_end;
  } position_t;

  function automatic logic [7:0] sat_shift8(input logic signed [17:0] t);
    logic [7:0] q;
    if (t < 0) begin
      q = 8'd0;
    end else if (t[16:8] > 9'd255) begin
      q = 8'd255;
    end else begin
      q = t[15:8];
    end
    return q;
  endfunction

endpackage

// ----- hw/rtl/rgbnv_if.sv -----
interface rgbnv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbnv_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_u;
  logic [7:0] chroma_v;
  logic       chroma_valid;
  logic       frame_end;

  modport source (output valid, output luma, output chroma_u, output chroma_v,
                  output chroma_valid, output frame_end, input ready);
  modport sink (input valid, input luma, input chroma_u, input chroma_v,
                input chroma_valid, input frame_end, output ready);
endinterface

// ----- hw/rtl/rgbnv_csc.sv -----
module rgbnv_csc (
  input  rgbnv_pkg::pixel_t    pixel,
  input  rgbnv_pkg::position_t pos,
  output rgbnv_pkg::result_t   result
);

  logic        [15:0] y_sum;
  logic signed [17:0] u_sum;
  logic signed [17:0] v_sum;
  logic signed [17:0] r_s;
  logic signed [17:0] g_s;
  logic signed [17:0] b_s;

  assign r_s = $signed({10'd0, pixel.red});
  assign g_s = $signed({10'd0, pixel.green});
  assign b_s = $signed({10'd0, pixel.blue});

  assign y_sum = 16'(16'd66 * pixel.red) + 16'(16'd129 * pixel.green)
               + 16'(16'd25 * pixel.blue);
  assign u_sum = 18'sd32768 + 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s;
  assign v_sum = 18'sd32768 + 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s;

  always_comb begin
    result.luma = rgbnv_pkg::sat_shift8($signed({2'b00, y_sum}) + 18'sd4096);
    result.chroma_valid = pos.chroma_valid;
    result.frame_end = pos.frame_end;
    if (pos.chroma_valid) begin
      result.chroma_u = rgbnv_pkg::sat_shift8(u_sum);
      result.chroma_v = rgbnv_pkg::sat_shift8(v_sum);
    end else begin
      result.chroma_u = 8'd0;
      result.chroma_v = 8'd0;
    end
  end

endmodule

// ----- hw/rtl/rgb_to_nv12_color_converter.sv -----
// Converts a raster stream of RGB pixels to BT.601 limited-range luma for every pixel and
// chroma for the top-left pixel of each complete 2x2 block, one word per clock. A pixel
// and its position flags pass an input register, then the color matrix into the result
// register. Both stages advance together whenever the result register is empty or being
// taken, so a new pixel is accepted in every cycle the output side is not stalled. Frame
// width and height are written through the configuration port by the user only while
// the stream is idle, which the block does not enforce; zero is treated as one.
module rgb_to_nv12_color_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rgbnv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgbnv_pkg::CFG_DATA_W-1:0]    cfg_data,
  rgbnv_pix_if.sink                           pix,
  rgbnv_res_if.source                         res
);

  localparam logic [rgbnv_pkg::CMP_W-1:0] MAX_DIM_C =
    rgbnv_pkg::CMP_W'(rgbnv_pkg::MAX_DIMENSION);

  logic [rgbnv_pkg::DIM_W-1:0] frame_width;
  logic [rgbnv_pkg::DIM_W-1:0] frame_height;
  logic [rgbnv_pkg::CMP_W-1:0] width_eff;
  logic [rgbnv_pkg::CMP_W-1:0] height_eff;
  logic [rgbnv_pkg::POS_W-1:0] column_position;
  logic [rgbnv_pkg::POS_W-1:0] row_position;
  logic [rgbnv_pkg::POS_W-1:0] column_position_next;
  logic [rgbnv_pkg::POS_W-1:0] row_position_next;
  logic                        last_col;
  logic                        last_row;
  logic                        advance;
  logic                        accept;

  rgbnv_pkg::position_t pos_in;
  rgbnv_pkg::pixel_t    s1_pixel;
  rgbnv_pkg::position_t s1_pos;
  logic                 s1_valid;
  rgbnv_pkg::result_t   result_comb;
  rgbnv_pkg::result_t   out_word;
  logic                 out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= rgbnv_pkg::FRAME_WIDTH_RESET;
      frame_height <= rgbnv_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rgbnv_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data;
        rgbnv_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = rgbnv_pkg::CMP_W'(frame_width);
    if (frame_width == '0) begin
      width_eff = rgbnv_pkg::CMP_W'(1);
    end else if (width_eff > MAX_DIM_C) begin
      width_eff = MAX_DIM_C;
    end
    height_eff = rgbnv_pkg::CMP_W'(frame_height);
    if (frame_height == '0) begin
      height_eff = rgbnv_pkg::CMP_W'(1);
    end else if (height_eff > MAX_DIM_C) begin
      height_eff = MAX_DIM_C;
    end
  end

  assign last_col = (rgbnv_pkg::CMP_W'(column_position) + rgbnv_pkg::CMP_W'(1)) >= width_eff;
  assign last_row = (rgbnv_pkg::CMP_W'(row_position) + rgbnv_pkg::CMP_W'(1)) >= height_eff;

  assign pos_in.chroma_valid = !column_position[0] && !row_position[0] && !last_col && !last_row;
  assign pos_in.frame_end = last_col && last_row;

  always_comb begin
    column_position_next = column_position + rgbnv_pkg::POS_W'(1);
    row_position_next = row_position;
    if (last_col) begin
      column_position_next = '0;
      row_position_next = last_row ? '0 : row_position + rgbnv_pkg::POS_W'(1);
    end
  end

  assign advance = !out_valid || res.ready;
  assign pix.ready = advance;
  assign accept = pix.valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position <= '0;
    end else if (accept) begin
      column_position <= column_position_next;
      row_position <= row_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pix.valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pixel <= '{red: pix.red, green: pix.green, blue: pix.blue};
      s1_pos <= pos_in;
      out_word <= result_comb;
    end
  end

  rgbnv_csc u_csc (
    .pixel  (s1_pixel),
    .pos    (s1_pos),
    .result (result_comb)
  );

  assign res.valid = out_valid;
  assign res.luma = out_word.luma;
  assign res.chroma_u = out_word.chroma_u;
  assign res.chroma_v = out_word.chroma_v;
  assign res.chroma_valid = out_word.chroma_valid;
  assign res.frame_end = out_word.frame_end;

`ifndef SYNTHESIS
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col && last_row |=> column_position == '0 && row_position == '0)
    else $error("Position counters did not return to zero after the last pixel.");

  a_column_step: assert property (@(posedge clk) disable iff (rst)
    accept && !last_col |=> column_position == $past(column_position) + rgbnv_pkg::POS_W'(1))
    else $error("Column counter did not advance by one within a row.");

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.chroma_valid |-> out_word.chroma_u == 8'd0
      && out_word.chroma_v == 8'd0)
    else $error("Chroma is nonzero on a word without valid chroma.");

  a_chroma_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.chroma_valid |-> !out_word.frame_end)
    else $error("Chroma marked valid on the last pixel of a frame.");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(column_position) && $stable(row_position))
    else $error("Position counters moved without an accepted word.");
`endif

endmodule

// ----- verif/tb_rgb_to_nv12_color_converter.sv -----
module tb_rgb_to_nv12_color_converter;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PIXELS = 1350;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [rgbnv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rgbnv_pkg::CFG_DATA_W-1:0] cfg_data;

  rgbnv_pix_if pix_bus ();
  rgbnv_res_if res_bus ();

  rgb_to_nv12_color_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_bus),
    .res       (res_bus)
  );

  rgbnv_pkg::pixel_t pending_pixels[$];
  rgbnv_pkg::result_t expected_yuv[$];

  logic [rgbnv_pkg::DIM_W-1:0] width_reg;
  logic [rgbnv_pkg::DIM_W-1:0] height_reg;
  int col_pos;
  int row_pos;

  int fail_count;
  int stall_cycles;
  bit steady_flow;

  rgbnv_pkg::pixel_t palette [8] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                     24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00};

  always #1 clk = ~clk;

  function automatic int clamp_dim(input logic [rgbnv_pkg::DIM_W-1:0] v);
    int d;
    d = v;
    if (d < 1) d = 1;
    if (d > rgbnv_pkg::MAX_DIMENSION) d = rgbnv_pkg::MAX_DIMENSION;
    return d;
  endfunction

  function automatic logic [7:0] sat8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic rgbnv_pkg::result_t convert_pixel(input rgbnv_pkg::pixel_t p);
    int w;
    int h;
    int ri;
    int gi;
    int bi;
    bit last_col;
    bit last_row;
    bit cv;
    rgbnv_pkg::result_t o;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    ri = p.red;
    gi = p.green;
    bi = p.blue;
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    cv = (col_pos % 2 == 0) && (row_pos % 2 == 0) && !last_col && !last_row;
    o.luma = sat8(((66 * ri + 129 * gi + 25 * bi) >>> 8) + 16);
    o.chroma_u = cv ? sat8(((-38 * ri - 74 * gi + 112 * bi) >>> 8) + 128) : 8'd0;
    o.chroma_v = cv ? sat8(((112 * ri - 94 * gi - 18 * bi) >>> 8) + 128) : 8'd0;
    o.chroma_valid = cv;
    o.frame_end = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) % 4096);
    end else begin
      col_pos = (col_pos + 1) % 4096;
    end
    return o;
  endfunction

  function automatic logic [7:0] random_component();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic rgbnv_pkg::pixel_t random_pixel();
    rgbnv_pkg::pixel_t p;
    if ($urandom_range(3) == 0) begin
      p.red = random_component();
      p.green = random_component();
      p.blue = random_component();
    end else begin
      p = 24'($urandom);
    end
    return p;
  endfunction

  function automatic logic [rgbnv_pkg::DIM_W-1:0] extreme_dim();
    case ($urandom_range(8))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd2;
      3: return 13'd3;
      4: return 13'd4095;
      5: return 13'd4096;
      6: return 13'd4097;
      7: return 13'd8191;
      default: return 13'($urandom_range(8191));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || pix_bus.valid || expected_yuv.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_dims(input logic [rgbnv_pkg::DIM_W-1:0] w,
                            input logic [rgbnv_pkg::DIM_W-1:0] h);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= rgbnv_pkg::REG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    width_reg = w;
    cfg_index <= rgbnv_pkg::REG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    height_reg = h;
    cfg_write <= 1'b0;
  endtask

  task automatic push_palette(input int count);
    for (int i = 0; i < count; i++) begin
      pending_pixels.push_back(palette[i % 8]);
    end
  endtask

  task automatic check_field(input string field, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rgbnv_pkg::pixel_t next_px;
    if (rst) begin
      pix_bus.valid <= 1'b0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        expected_yuv.push_back(convert_pixel({pix_bus.red, pix_bus.green, pix_bus.blue}));
      end
      if (!pix_bus.valid || pix_bus.ready) begin
        if (pending_pixels.size() != 0 && (steady_flow || $urandom_range(99) >= 32)) begin
          next_px = pending_pixels.pop_front();
          pix_bus.valid <= 1'b1;
          pix_bus.red <= next_px.red;
          pix_bus.green <= next_px.green;
          pix_bus.blue <= next_px.blue;
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rgbnv_pkg::result_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_yuv.size() == 0) begin
          $display("%0t unexpected result word: expected none, actual luma %0d",
                   $time, res_bus.luma);
          fail_count++;
        end else begin
          want = expected_yuv.pop_front();
          check_field("luma", want.luma, res_bus.luma);
          check_field("chroma_u", want.chroma_u, res_bus.chroma_u);
          check_field("chroma_v", want.chroma_v, res_bus.chroma_v);
          check_field("chroma_valid", want.chroma_valid, res_bus.chroma_valid);
          check_field("frame_end", want.frame_end, res_bus.frame_end);
        end
      end
      res_bus.ready <= steady_flow || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [rgbnv_pkg::DIM_W-1:0] w;
    logic [rgbnv_pkg::DIM_W-1:0] h;
    int sent_count;
    int phase;
    int quiet_phase;
    int frame_px;
    int count;
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_bus.valid = 1'b0;
    pix_bus.red = 8'd0;
    pix_bus.green = 8'd0;
    pix_bus.blue = 8'd0;
    res_bus.ready = 1'b0;
    fail_count = 0;
    stall_cycles = 0;
    steady_flow = 1'b0;
    width_reg = rgbnv_pkg::FRAME_WIDTH_RESET;
    height_reg = rgbnv_pkg::FRAME_HEIGHT_RESET;
    col_pos = 0;
    row_pos = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The first words run at the reset dimensions; each later setting lands mid-frame,
    // so a column or row already past the new limit has to close the row or the frame.
    push_palette(3);
    apply_dims(13'd3, 13'd3);
    push_palette(9);
    apply_dims(13'd2, 13'd16);
    push_palette(6);
    apply_dims(13'd0, 13'd2);
    push_palette(2);
    apply_dims(13'd8191, 13'd8191);
    push_palette(2);

    sent_count = 0;
    phase = 0;
    quiet_phase = $urandom_range(3, 8);
    while (sent_count < RANDOM_PIXELS) begin
      phase++;
      if ($urandom_range(9) == 0) begin
        w = extreme_dim();
        h = extreme_dim();
      end else begin
        w = 13'($urandom_range(1, 12));
        h = 13'($urandom_range(1, 12));
      end
      apply_dims(w, h);
      steady_flow = (phase == quiet_phase);
      frame_px = clamp_dim(w) * clamp_dim(h);
      if (steady_flow) begin
        count = 250;
      end else if (frame_px <= 120 && $urandom_range(3) != 0) begin
        count = frame_px * $urandom_range(1, 3);
      end else begin
        count = $urandom_range(1, 100);
      end
      if (count > RANDOM_PIXELS - sent_count) begin
        count = RANDOM_PIXELS - sent_count;
      end
      for (int i = 0; i < count; i++) begin
        pending_pixels.push_back(random_pixel());
      end
      sent_count += count;
    end

    wait_drained();
    steady_flow = 1'b0;
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
